### rtl/id3_pkg.sv
// Shared types, constants and field helpers for the ID3v2 text-frame extractor.
package id3_pkg;

   typedef enum logic [2:0] {
      PH_HDR  = 3'd0,
      PH_EXT  = 3'd1,
      PH_FHDR = 3'd2,
      PH_SKIP = 3'd3,
      PH_DLI  = 3'd4,
      PH_ENC  = 3'd5,
      PH_TEXT = 3'd6,
      PH_DONE = 3'd7
   } phase_type;

   localparam logic [1:0] EV_PAYLOAD = 2'd0;
   localparam logic [1:0] EV_REJECT  = 2'd1;
   localparam logic [1:0] EV_TAG_END = 2'd2;

   localparam logic [2:0] KIND_NONE   = 3'd0;
   localparam logic [2:0] KIND_ARTIST = 3'd1;
   localparam logic [2:0] KIND_ALBUM  = 3'd2;
   localparam logic [2:0] KIND_TITLE  = 3'd3;
   localparam logic [2:0] KIND_TRACK  = 3'd4;

   localparam logic [23:0] TAG_MAGIC = 24'h494433;
   localparam logic [31:0] ID4_ARTIST = 32'h54504531;
   localparam logic [31:0] ID4_ALBUM  = 32'h54414C42;
   localparam logic [31:0] ID4_TITLE  = 32'h54495432;
   localparam logic [31:0] ID4_TRACK  = 32'h5452434B;
   localparam logic [23:0] ID3_ARTIST = 24'h545031;
   localparam logic [23:0] ID3_ALBUM  = 24'h54414C;
   localparam logic [23:0] ID3_TITLE  = 24'h545432;
   localparam logic [23:0] ID3_TRACK  = 24'h54524B;

   localparam logic [3:0] HDR_LEN    = 4'd10;
   localparam logic [3:0] FHDR_LEN22 = 4'd6;
   localparam logic [3:0] FHDR_LEN23 = 4'd10;
   localparam logic [3:0] EXT_LEN    = 4'd4;
   localparam logic [3:0] DLI_LEN    = 4'd4;

   function automatic logic [27:0] ss28(input logic [7:0] b0, input logic [7:0] b1,
                                        input logic [7:0] b2, input logic [7:0] b3);
      ss28 = {b0[6:0], b1[6:0], b2[6:0], b3[6:0]};
   endfunction

   function automatic logic [31:0] sat32(input logic [33:0] v);
      sat32 = (v[33:32] != 2'd0) ? 32'hFFFF_FFFF : v[31:0];
   endfunction

endpackage

### rtl/id3v2_text_frame_extractor.sv
// Top level of the ID3v2 text-frame extractor: byte-wide tag parser with a result register.
//
//   channel | direction | tdata           | tuser                          | tlast
//   req     | in        | in_byte         | file_start                     | -
//   rsp     | out       | data_byte       | event, kind, encoding, first   | last_of_frame
//
// One byte beat is accepted every cycle while req_tready is high; its result beat, if any, appears in the next cycle.
// All parsing is one pass of logic between the state registers and the result register.
// A stalled result register holds req_tready low until its beat is taken.
// Reset clears the parser to expect a tag header and empties the result register.
module id3v2_text_frame_extractor (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   input  logic       req_tuser,   // [0] file_start
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] data_byte
   output logic [6:0] rsp_tuser,   // [1:0] event_res, [3:2] field_kind, [5:4] text_encoding,
                                   // [6] first_of_frame
   output logic       rsp_tlast    // last_of_frame
);
   import id3_pkg::*;

   phase_type   phase_ff, phase_in, ph_cur;
   logic [3:0]  idx_ff, idx_in, idx_cur;
   logic [7:0]  hdr_ff [10];
   logic [7:0]  hdr_in [10];
   logic [7:0]  hv [10];
   logic        hdr_we;
   logic [2:0]  major_ff, major_in;
   logic [27:0] tag_size_ff, tag_size_in;
   logic [31:0] consumed_ff, consumed_in;
   logic [31:0] remain_ff, remain_in, remain_dec;
   logic [2:0]  kind_ff, kind_in;
   logic [1:0]  enc_ff, enc_in;
   logic        unsync_ff, unsync_in;
   logic        prev_ff_ff, prev_ff_in;
   logic        first_ff, first_in;

   logic        req_fire;
   logic        emit;
   logic [1:0]  emit_ev;
   logic [1:0]  emit_kind;
   logic [1:0]  emit_enc;
   logic        emit_first;
   logic        emit_last;

   logic        rsp_valid_ff;
   logic [7:0]  rsp_data_ff;
   logic [6:0]  rsp_user_ff;
   logic        rsp_last_ff;

   logic [7:0]  b;
   logic [3:0]  hlen;
   logic        hdr_ok;
   logic [27:0] ext_ss;
   logic [31:0] ext_rem;
   logic [31:0] fr_size;
   logic [2:0]  fr_kind;
   logic        fr_zero;
   logic [33:0] ext_sum;
   logic [33:0] fr_sum;
   logic        tag_end;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;
   assign b          = req_tdata;

   assign ph_cur  = req_tuser ? PH_HDR : phase_ff;
   assign idx_cur = req_tuser ? 4'd0 : idx_ff;

   always_comb begin
      for (int i = 0; i < 10; i++) begin
         hv[i] = (idx_cur == 4'(i)) ? b : hdr_ff[i];
      end
   end

   assign hlen = (major_ff == 3'd2) ? FHDR_LEN22 : FHDR_LEN23;

   assign hdr_ok = ({hv[0], hv[1], hv[2]} == TAG_MAGIC) && (hv[3] != 8'hFF) &&
                   (hv[4] != 8'hFF) && (hv[5][3:0] == 4'd0) && !hv[6][7] && !hv[7][7] &&
                   !hv[8][7] && !hv[9][7] && (hv[3] >= 8'd2) && (hv[3] <= 8'd4);

   assign ext_ss  = ss28(hv[0], hv[1], hv[2], hv[3]);
   assign ext_rem = (major_ff == 3'd3) ? {hv[0], hv[1], hv[2], hv[3]} :
                    (ext_ss >= 28'd4) ? {4'd0, ext_ss - 28'd4} : 32'd0;
   assign ext_sum = {2'd0, consumed_ff} + 34'd4 + {2'd0, ext_rem};

   always_comb begin
      fr_zero = 1'b1;
      for (int i = 0; i < 10; i++) begin
         if ((4'(i) < hlen) && (hv[i] != 8'd0)) begin
            fr_zero = 1'b0;
         end
      end
   end

   always_comb begin
      if (major_ff == 3'd2) begin
         fr_size = {8'd0, hv[3], hv[4], hv[5]};
         priority if ({hv[0], hv[1], hv[2]} == ID3_ARTIST) fr_kind = KIND_ARTIST;
         else if ({hv[0], hv[1], hv[2]} == ID3_ALBUM) fr_kind = KIND_ALBUM;
         else if ({hv[0], hv[1], hv[2]} == ID3_TITLE) fr_kind = KIND_TITLE;
         else if ({hv[0], hv[1], hv[2]} == ID3_TRACK) fr_kind = KIND_TRACK;
         else fr_kind = KIND_NONE;
      end else begin
         fr_size = (major_ff == 3'd4) ? {4'd0, ss28(hv[4], hv[5], hv[6], hv[7])} :
                                        {hv[4], hv[5], hv[6], hv[7]};
         priority if ({hv[0], hv[1], hv[2], hv[3]} == ID4_ARTIST) fr_kind = KIND_ARTIST;
         else if ({hv[0], hv[1], hv[2], hv[3]} == ID4_ALBUM) fr_kind = KIND_ALBUM;
         else if ({hv[0], hv[1], hv[2], hv[3]} == ID4_TITLE) fr_kind = KIND_TITLE;
         else if ({hv[0], hv[1], hv[2], hv[3]} == ID4_TRACK) fr_kind = KIND_TRACK;
         else fr_kind = KIND_NONE;
      end
   end

   assign fr_sum  = {2'd0, consumed_ff} + {30'd0, hlen} + {2'd0, fr_size};
   assign tag_end = ({1'b0, consumed_ff} + {29'd0, hlen}) >= {5'd0, tag_size_ff};
   assign remain_dec = remain_ff - 32'd1;

   always_comb begin
      phase_in    = ph_cur;
      idx_in      = idx_cur;
      hdr_we      = 1'b0;
      major_in    = major_ff;
      tag_size_in = tag_size_ff;
      consumed_in = consumed_ff;
      remain_in   = remain_ff;
      kind_in     = kind_ff;
      enc_in      = enc_ff;
      unsync_in   = unsync_ff;
      prev_ff_in  = prev_ff_ff;
      first_in    = first_ff;
      emit        = 1'b0;
      emit_ev     = EV_PAYLOAD;
      emit_kind   = 2'd0;
      emit_enc    = 2'd0;
      emit_first  = 1'b0;
      emit_last   = 1'b0;
      unique case (ph_cur)
         PH_HDR: begin
            hdr_we = 1'b1;
            idx_in = idx_cur + 4'd1;
            if (idx_cur == HDR_LEN - 4'd1) begin
               idx_in = 4'd0;
               if (!hdr_ok) begin
                  phase_in = PH_DONE;
                  emit     = 1'b1;
                  emit_ev  = EV_REJECT;
               end else begin
                  major_in    = hv[3][2:0];
                  tag_size_in = ss28(hv[6], hv[7], hv[8], hv[9]);
                  consumed_in = 32'd0;
                  phase_in    = (hv[3] >= 8'd3 && hv[5][6]) ? PH_EXT : PH_FHDR;
               end
            end
         end
         PH_EXT: begin
            hdr_we = 1'b1;
            idx_in = idx_cur + 4'd1;
            if (idx_cur == EXT_LEN - 4'd1) begin
               idx_in      = 4'd0;
               consumed_in = sat32(ext_sum);
               remain_in   = ext_rem;
               phase_in    = (ext_rem != 32'd0) ? PH_SKIP : PH_FHDR;
            end
         end
         PH_FHDR: begin
            if (idx_cur == 4'd0 && tag_end) begin
               phase_in = PH_DONE;
               emit     = 1'b1;
               emit_ev  = EV_TAG_END;
            end else begin
               hdr_we = 1'b1;
               idx_in = idx_cur + 4'd1;
               if (idx_cur == hlen - 4'd1) begin
                  idx_in = 4'd0;
                  if (fr_zero) begin
                     phase_in = PH_DONE;
                     emit     = 1'b1;
                     emit_ev  = EV_TAG_END;
                  end else begin
                     kind_in     = fr_kind;
                     unsync_in   = (major_ff == 3'd4) && hv[9][1];
                     consumed_in = sat32(fr_sum);
                     if (fr_size != 32'd0) begin
                        remain_in = fr_size;
                        priority if (fr_kind == KIND_NONE) phase_in = PH_SKIP;
                        else if (major_ff == 3'd4 && hv[9][0]) phase_in = PH_DLI;
                        else phase_in = PH_ENC;
                     end
                  end
               end
            end
         end
         PH_SKIP: begin
            remain_in = remain_dec;
            if (remain_dec == 32'd0) begin
               phase_in = PH_FHDR;
               idx_in   = 4'd0;
            end
         end
         PH_DLI: begin
            remain_in = remain_dec;
            idx_in    = idx_cur + 4'd1;
            if (remain_dec == 32'd0) begin
               phase_in = PH_FHDR;
               idx_in   = 4'd0;
            end else if (idx_cur + 4'd1 >= DLI_LEN) begin
               phase_in = PH_ENC;
               idx_in   = 4'd0;
            end
         end
         PH_ENC: begin
            remain_in = remain_dec;
            if (remain_dec == 32'd0) begin
               phase_in = PH_FHDR;
               idx_in   = 4'd0;
            end else if (b > 8'd3) begin
               phase_in = PH_SKIP;
            end else begin
               enc_in     = b[1:0];
               prev_ff_in = 1'b0;
               first_in   = 1'b1;
               phase_in   = PH_TEXT;
            end
         end
         PH_TEXT: begin
            remain_in = remain_dec;
            if (unsync_ff && prev_ff_ff && b == 8'd0 && remain_dec != 32'd0) begin
               prev_ff_in = 1'b0;
            end else begin
               emit       = 1'b1;
               emit_ev    = EV_PAYLOAD;
               emit_kind  = 2'(kind_ff - 3'd1);
               emit_enc   = enc_ff;
               emit_first = first_ff;
               emit_last  = (remain_dec == 32'd0);
               first_in   = 1'b0;
               prev_ff_in = (b == 8'hFF);
               if (remain_dec == 32'd0) begin
                  phase_in = PH_FHDR;
                  idx_in   = 4'd0;
               end
            end
         end
         PH_DONE: begin
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      hdr_in = hdr_ff;
      if (hdr_we) begin
         hdr_in = hv;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HDR;
         idx_ff       <= 4'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            phase_ff <= phase_in;
            idx_ff   <= idx_in;
         end
         if (req_tready) begin
            rsp_valid_ff <= req_fire && emit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         hdr_ff      <= hdr_in;
         major_ff    <= major_in;
         tag_size_ff <= tag_size_in;
         consumed_ff <= consumed_in;
         remain_ff   <= remain_in;
         kind_ff     <= kind_in;
         enc_ff      <= enc_in;
         unsync_ff   <= unsync_in;
         prev_ff_ff  <= prev_ff_in;
         first_ff    <= first_in;
      end
      if (req_fire && emit) begin
         rsp_data_ff <= (emit_ev == EV_PAYLOAD) ? b : 8'd0;
         rsp_user_ff <= {emit_first, emit_enc, emit_kind, emit_ev};
         rsp_last_ff <= emit_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

### tb/id3v2_text_frame_extractor_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the ID3v2 text-frame extractor: directed and random tags, stalls.
module id3v2_text_frame_extractor_tb;
   import id3_pkg::*;

   typedef bit [7:0] octets_type[$];

   typedef struct packed {
      bit [1:0] ev;
      bit [1:0] kind;
      bit [1:0] enc;
      bit [7:0] data;
      bit       is_first;
      bit       is_last;
   } text_beat_type;

   // Shadow of the tag parser; it keeps the text beats still owed by the block.
   class tag_walker;
      phase_type     stage;
      bit [7:0]      hbuf[10];
      int unsigned   hcount;
      bit [7:0]      ver;
      bit [31:0]     tag_len;
      bit [31:0]     used;
      bit [31:0]     left;
      bit [2:0]      kind_now;
      bit [1:0]      enc_now;
      bit            unsync_now;
      bit            after_ff;
      bit            first_due;
      text_beat_type owed_beats[$];
      int            mismatches;
      int            parsed_bytes;

      function new();
         restart();
         mismatches = 0;
         parsed_bytes = 0;
      endfunction

      function void restart();
         stage = PH_HDR;
         foreach (hbuf[i]) hbuf[i] = 8'h00;
         hcount = 0;
         ver = 8'd0;
         tag_len = 32'd0;
         used = 32'd0;
         left = 32'd0;
         kind_now = KIND_NONE;
         enc_now = 2'd0;
         unsync_now = 1'b0;
         after_ff = 1'b0;
         first_due = 1'b0;
      endfunction

      function bit [31:0] synch_at(int o);
         return {4'd0, hbuf[o][6:0], hbuf[o+1][6:0], hbuf[o+2][6:0], hbuf[o+3][6:0]};
      endfunction

      function bit [31:0] be_at(int o);
         return {hbuf[o], hbuf[o+1], hbuf[o+2], hbuf[o+3]};
      endfunction

      function void add_used(bit [63:0] n);
         bit [63:0] sum;
         sum = {32'd0, used} + n;
         used = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
      endfunction

      function void owe(bit [1:0] ev, bit [1:0] kind, bit [1:0] enc, bit [7:0] data,
                        bit f, bit l);
         text_beat_type t;
         t.ev = ev;
         t.kind = kind;
         t.enc = enc;
         t.data = data;
         t.is_first = f;
         t.is_last = l;
         owed_beats.push_back(t);
      endfunction

      function void to_header();
         stage = PH_FHDR;
         hcount = 0;
      endfunction

      function void take_byte(bit [7:0] b, bit start);
         bit          ok;
         bit          all_zero;
         bit          dli;
         bit          fin;
         bit          was_first;
         bit [31:0]   size;
         bit [31:0]   rem;
         bit [23:0]   id3;
         bit [31:0]   id4;
         int unsigned hlen;
         int          i;
         if (start) restart();
         parsed_bytes++;
         hlen = (ver == 8'd2) ? 6 : 10;
         case (stage)
            PH_HDR: begin
               hbuf[hcount] = b;
               hcount++;
               if (hcount == 10) begin
                  hcount = 0;
                  ok = {hbuf[0], hbuf[1], hbuf[2]} == TAG_MAGIC && hbuf[3] != 8'hFF &&
                       hbuf[4] != 8'hFF && hbuf[5][3:0] == 4'h0 && !hbuf[6][7] &&
                       !hbuf[7][7] && !hbuf[8][7] && !hbuf[9][7];
                  if (!ok || hbuf[3] < 8'd2 || hbuf[3] > 8'd4) begin
                     stage = PH_DONE;
                     owe(EV_REJECT, 2'd0, 2'd0, 8'd0, 1'b0, 1'b0);
                  end else begin
                     ver = hbuf[3];
                     tag_len = synch_at(6);
                     used = 32'd0;
                     stage = (ver >= 8'd3 && hbuf[5][6]) ? PH_EXT : PH_FHDR;
                  end
               end
            end
            PH_EXT: begin
               hbuf[hcount] = b;
               hcount++;
               if (hcount == 4) begin
                  hcount = 0;
                  if (ver == 8'd3) rem = be_at(0);
                  else rem = (synch_at(0) >= 32'd4) ? synch_at(0) - 32'd4 : 32'd0;
                  add_used(64'd4 + {32'd0, rem});
                  left = rem;
                  if (rem != 32'd0) stage = PH_SKIP;
                  else to_header();
               end
            end
            PH_FHDR: begin
               if (hcount == 0 && {32'd0, used} + 64'(hlen) >= {32'd0, tag_len}) begin
                  stage = PH_DONE;
                  owe(EV_TAG_END, 2'd0, 2'd0, 8'd0, 1'b0, 1'b0);
               end else begin
                  hbuf[hcount] = b;
                  hcount++;
                  if (hcount == hlen) begin
                     hcount = 0;
                     all_zero = 1'b1;
                     for (i = 0; i < hlen; i++) if (hbuf[i] != 8'h00) all_zero = 1'b0;
                     if (all_zero) begin
                        stage = PH_DONE;
                        owe(EV_TAG_END, 2'd0, 2'd0, 8'd0, 1'b0, 1'b0);
                     end else begin
                        id3 = {hbuf[0], hbuf[1], hbuf[2]};
                        id4 = {hbuf[0], hbuf[1], hbuf[2], hbuf[3]};
                        if (ver == 8'd2) begin
                           size = {8'd0, hbuf[3], hbuf[4], hbuf[5]};
                           kind_now = (id3 == ID3_ARTIST) ? KIND_ARTIST :
                                      (id3 == ID3_ALBUM)  ? KIND_ALBUM  :
                                      (id3 == ID3_TITLE)  ? KIND_TITLE  :
                                      (id3 == ID3_TRACK)  ? KIND_TRACK  : KIND_NONE;
                        end else begin
                           size = (ver == 8'd4) ? synch_at(4) : be_at(4);
                           kind_now = (id4 == ID4_ARTIST) ? KIND_ARTIST :
                                      (id4 == ID4_ALBUM)  ? KIND_ALBUM  :
                                      (id4 == ID4_TITLE)  ? KIND_TITLE  :
                                      (id4 == ID4_TRACK)  ? KIND_TRACK  : KIND_NONE;
                        end
                        unsync_now = ver == 8'd4 && hbuf[9][1];
                        dli = ver == 8'd4 && hbuf[9][0];
                        add_used(64'(hlen) + {32'd0, size});
                        if (size != 32'd0) begin
                           left = size;
                           if (kind_now == KIND_NONE) stage = PH_SKIP;
                           else if (dli) stage = PH_DLI;
                           else stage = PH_ENC;
                        end
                     end
                  end
               end
            end
            PH_SKIP: begin
               left--;
               if (left == 32'd0) to_header();
            end
            PH_DLI: begin
               left--;
               hcount++;
               if (left == 32'd0) begin
                  to_header();
               end else if (hcount >= 4) begin
                  hcount = 0;
                  stage = PH_ENC;
               end
            end
            PH_ENC: begin
               left--;
               if (left == 32'd0) begin
                  to_header();
               end else if (b > 8'd3) begin
                  stage = PH_SKIP;
               end else begin
                  enc_now = b[1:0];
                  after_ff = 1'b0;
                  first_due = 1'b1;
                  stage = PH_TEXT;
               end
            end
            PH_TEXT: begin
               left--;
               fin = (left == 32'd0);
               if (unsync_now && after_ff && b == 8'h00 && !fin) begin
                  after_ff = 1'b0;
               end else begin
                  was_first = first_due;
                  first_due = 1'b0;
                  after_ff = (b == 8'hFF);
                  if (fin) to_header();
                  owe(EV_PAYLOAD, 2'(kind_now - KIND_ARTIST), enc_now, b, was_first, fin);
               end
            end
            default: ;
         endcase
      endfunction

      task flag_mismatch(string what, int unsigned want, int unsigned got);
         $display("%0t: mismatch in %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
         mismatches++;
      endtask

      task match_beat(bit [7:0] data, bit [6:0] user, bit tl);
         text_beat_type want;
         if (owed_beats.size() == 0) begin
            flag_mismatch("unexpected result beat", 0, {tl, user, data});
            return;
         end
         want = owed_beats.pop_front();
         if (user[1:0] != want.ev) flag_mismatch("event", want.ev, user[1:0]);
         if (user[3:2] != want.kind) flag_mismatch("field kind", want.kind, user[3:2]);
         if (user[5:4] != want.enc) flag_mismatch("text encoding", want.enc, user[5:4]);
         if (data != want.data) flag_mismatch("data byte", want.data, data);
         if (user[6] != want.is_first) flag_mismatch("first of frame", want.is_first, user[6]);
         if (tl != want.is_last) flag_mismatch("last of frame", want.is_last, tl);
      endtask
   endclass

   logic       clock;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;
   logic       req_tuser = 1'b0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic [6:0] rsp_tuser;
   logic       rsp_tlast;

   bit         gaps_on = 1'b1;
   octets_type stim;
   tag_walker  walker = new();

   id3v2_text_frame_extractor DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_tready <= !(gaps_on && $urandom_range(0, 99) < 15);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) walker.match_beat(rsp_tdata, rsp_tuser, rsp_tlast);
         if (req_tvalid && req_tready) walker.take_byte(req_tdata, req_tuser);
      end
   end

   function automatic void put(bit [7:0] b);
      stim.push_back(b);
   endfunction

   function automatic octets_type synch4(bit [27:0] s, bit noisy);
      octets_type q;
      q.push_back({noisy & 1'($urandom_range(0, 1)), s[27:21]});
      q.push_back({noisy & 1'($urandom_range(0, 1)), s[20:14]});
      q.push_back({noisy & 1'($urandom_range(0, 1)), s[13:7]});
      q.push_back({noisy & 1'($urandom_range(0, 1)), s[6:0]});
      return q;
   endfunction

   function automatic void put_frame_header(int major, bit [31:0] id, bit [7:0] fl2,
                                            bit [31:0] size);
      if (major == 2) begin
         put(id[23:16]);
         put(id[15:8]);
         put(id[7:0]);
         put(size[23:16]);
         put(size[15:8]);
         put(size[7:0]);
      end else begin
         put(id[31:24]);
         put(id[23:16]);
         put(id[15:8]);
         put(id[7:0]);
         if (major == 4) begin
            stim = {stim, synch4(size[27:0], 1'b1)};
         end else begin
            put(size[31:24]);
            put(size[23:16]);
            put(size[15:8]);
            put(size[7:0]);
         end
         put(8'($urandom_range(0, 255)));
         put(fl2);
      end
   endfunction

   function automatic void put_text_frame(int major, bit [31:0] id, bit [7:0] fl2,
                                          bit [7:0] encb, string s);
      int i;
      put_frame_header(major, id, fl2, s.len() + 1);
      put(encb);
      for (i = 0; i < s.len(); i++) put(s[i]);
   endfunction

   function automatic octets_type tag_head(int major, bit [7:0] rev, bit [7:0] flags,
                                           bit [27:0] size);
      octets_type q;
      q = {TAG_MAGIC[23:16], TAG_MAGIC[15:8], TAG_MAGIC[7:0], 8'(major), rev, flags};
      return {q, synch4(size, 1'b0)};
   endfunction

   function automatic void wrap_tag(int major, bit [7:0] flags, int pad);
      repeat (pad) put(8'h00);
      stim = {tag_head(major, 8'h00, flags, 28'(stim.size())), stim};
   endfunction

   task automatic send_byte(bit [7:0] b, bit start);
      while (gaps_on && $urandom_range(0, 99) < 15) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      req_tuser <= start;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic send_stim(bit start);
      foreach (stim[i]) send_byte(stim[i], start && i == 0);
      stim.delete();
   endtask

   task automatic run_directed();
      octets_type h;
      int         i;
      // The first tag goes in without a file start beat, straight after reset.
      put_text_frame(3, ID4_ARTIST, 8'h00, 8'd0, "Ann");
      put_text_frame(3, ID4_ALBUM, 8'h00, 8'd1, "Bq");
      put_frame_header(3, "COMM", 8'h00, 3);
      put(8'h01);
      put(8'h02);
      put(8'h03);
      put_text_frame(3, ID4_TITLE, 8'h00, 8'd3, "T");
      put_text_frame(3, ID4_TRACK, 8'h00, 8'd2, "12");
      wrap_tag(3, 8'h00, 12);
      put(8'h55);
      send_stim(1'b0);

      put_text_frame(2, ID3_ARTIST, 8'h00, 8'd0, "Al");
      put_text_frame(2, ID3_ALBUM, 8'h00, 8'd1, "x");
      put_text_frame(2, ID3_TITLE, 8'h00, 8'd2, "Song");
      put_text_frame(2, ID3_TRACK, 8'h00, 8'd3, "7");
      put_frame_header(2, "COM", 8'h00, 2);
      put(8'hAA);
      put(8'hBB);
      wrap_tag(2, 8'h00, 0);
      put(8'h11);
      send_stim(1'b1);

      // Extended header, data-length bytes and unsynchronisation, with 0x00 after 0xFF
      // as the final raw byte of a frame.
      stim = synch4(28'd6, 1'b0);
      put(8'h12);
      put(8'h34);
      put_frame_header(4, ID4_ARTIST, 8'h03, 13);
      put(8'h00);
      put(8'h00);
      put(8'h00);
      put(8'h08);
      put(8'h03);
      put(8'hFF);
      put(8'h00);
      put(8'h41);
      put(8'hFF);
      put(8'hFF);
      put(8'h00);
      put(8'hFF);
      put(8'h00);
      put_frame_header(4, ID4_TITLE, 8'h02, 6);
      put(8'h00);
      put(8'hFF);
      put(8'h00);
      put(8'h00);
      put(8'hFF);
      put(8'h42);
      put_frame_header(4, ID4_ALBUM, 8'h01, 3);
      put(8'h01);
      put(8'h02);
      put(8'h03);
      put_frame_header(4, ID4_TRACK, 8'h00, 4);
      put(8'h00);
      put(8'hFF);
      put(8'h00);
      put(8'h35);
      wrap_tag(4, 8'h40, 10);
      send_stim(1'b1);

      stim = synch4(28'd2, 1'b0);
      put_text_frame(4, ID4_TITLE, 8'h00, 8'd0, "ab");
      wrap_tag(4, 8'h40, 3);
      put(8'h01);
      send_stim(1'b1);

      // Empty text, a zero-size frame and an encoding code above 3.
      put(8'h00);
      put(8'h00);
      put(8'h00);
      put(8'h06);
      repeat (6) put(8'hEE);
      put_frame_header(3, ID4_ARTIST, 8'h00, 1);
      put(8'h00);
      put_frame_header(3, ID4_ALBUM, 8'h00, 0);
      put_text_frame(3, ID4_TITLE, 8'h00, 8'd4, "zz");
      put_text_frame(3, ID4_TRACK, 8'h00, 8'd0, "9");
      wrap_tag(3, 8'h40, 0);
      put(8'h02);
      send_stim(1'b1);

      put_text_frame(2, ID3_TITLE, 8'h00, 8'd3, "t");
      wrap_tag(2, 8'h40, 6);
      send_stim(1'b1);

      for (i = 0; i < 7; i++) begin
         h = tag_head(3, 8'h00, 8'h00, 28'd20);
         case (i)
            0: h[2] = 8'h34;
            1: h[3] = 8'hFF;
            2: h[4] = 8'hFF;
            3: h[5] = 8'h01;
            4: h[8] = 8'h80;
            5: h[3] = 8'h01;
            default: h[3] = 8'h05;
         endcase
         stim = h;
         put(8'h54);
         put(8'h00);
         send_stim(1'b1);
      end

      // Huge sizes saturate the consumed count; the next file start cuts them short.
      stim = tag_head(3, 8'h00, 8'h40, 28'd100);
      repeat (4) put(8'hFF);
      put(8'h01);
      send_stim(1'b1);
      stim = tag_head(3, 8'h00, 8'h00, 28'd100);
      put_text_frame(3, ID4_ARTIST, 8'h00, 8'd0, "xyz");
      stim[14] = 8'hFF;
      stim[15] = 8'hFF;
      stim[16] = 8'hFF;
      stim[17] = 8'hF0;
      send_stim(1'b1);

      put(TAG_MAGIC[23:16]);
      put(TAG_MAGIC[15:8]);
      put(TAG_MAGIC[7:0]);
      send_stim(1'b1);
   endtask

   task automatic random_file();
      int          major;
      int          len;
      int          k;
      bit [7:0]    flags;
      bit [7:0]    fl2;
      bit [31:0]   id;
      bit [27:0]   tsize;
      bit          is_text;
      bit          dli;
      octets_type  h;
      major = $urandom_range(2, 4);
      flags = {4'($urandom_range(0, 15)), 4'h0};
      if (flags[6] && major == 3) begin
         len = $urandom_range(0, 6);
         put(8'h00);
         put(8'h00);
         put(8'h00);
         put(8'(len));
         repeat (len) put(8'($urandom_range(0, 255)));
      end else if (flags[6] && major == 4) begin
         len = $urandom_range(0, 10);
         stim = {stim, synch4(28'(len), 1'b1)};
         repeat (len > 4 ? len - 4 : 0) put(8'($urandom_range(0, 255)));
      end
      repeat ($urandom_range(0, 5)) begin
         is_text = $urandom_range(0, 4) != 0;
         if (is_text) begin
            case ($urandom_range(0, 3))
               0: id = (major == 2) ? {8'd0, ID3_ARTIST} : ID4_ARTIST;
               1: id = (major == 2) ? {8'd0, ID3_ALBUM} : ID4_ALBUM;
               2: id = (major == 2) ? {8'd0, ID3_TITLE} : ID4_TITLE;
               default: id = (major == 2) ? {8'd0, ID3_TRACK} : ID4_TRACK;
            endcase
         end else begin
            id = {8'($urandom_range(65, 90)), 8'($urandom_range(65, 90)),
                  8'($urandom_range(65, 90)), 8'($urandom_range(48, 57))};
         end
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 40) : $urandom_range(0, 10);
         fl2 = 8'($urandom_range(0, 255));
         dli = major == 4 && fl2[0];
         put_frame_header(major, id, fl2, len);
         for (k = 0; k < len; k++) begin
            if (is_text && k == (dli ? 4 : 0)) begin
               put(8'(($urandom_range(0, 7) == 0) ? $urandom_range(4, 255)
                                                   : $urandom_range(0, 3)));
            end else begin
               case ($urandom_range(0, 3))
                  0: put(8'hFF);
                  1: put(8'h00);
                  default: put(8'($urandom_range(0, 255)));
               endcase
            end
         end
      end
      repeat ($urandom_range(0, 12)) put(8'h00);
      tsize = 28'(stim.size());
      if ($urandom_range(0, 5) == 0) tsize = 28'($urandom_range(0, tsize));
      h = tag_head(major, 8'($urandom_range(0, 254)), flags, tsize);
      if ($urandom_range(0, 11) == 0) h[$urandom_range(0, 9)] = 8'($urandom_range(0, 255));
      stim = {h, stim};
      repeat ($urandom_range(0, 2)) put(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 15) == 0) stim = stim[0:$urandom_range(0, stim.size() - 1)];
      send_stim(1'b1);
   endtask

   initial begin
      int w;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      while (walker.parsed_bytes < 1800) begin
         gaps_on = !(walker.parsed_bytes >= 700 && walker.parsed_bytes < 1100);
         random_file();
      end
      req_tvalid <= 1'b0;
      w = 0;
      while (walker.owed_beats.size() != 0 && w < 2000) begin
         @(posedge clock);
         w++;
      end
      repeat (10) @(posedge clock);
      foreach (walker.owed_beats[i])
         walker.flag_mismatch("missing result beat", walker.owed_beats[i].data, 0);
      if (walker.mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #3_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
